FILE: hw/rtl/ps2mf_pkg.sv
package ps2mf_pkg;

    // Default number of ring slots; one slot always stays free.
    localparam int QUEUE_DEPTH_DEF = 256;

    // Packed event layout: buttons [2:0], x_move [11:3], y_move [21:12].
    localparam int BUTTONS_W = 3;
    localparam int X_MOVE_W  = 9;
    localparam int Y_MOVE_W  = 10;
    localparam int EVENT_W   = BUTTONS_W + X_MOVE_W + Y_MOVE_W;
    localparam int LEFT_W    = 8;
    localparam int BYTE_W    = 8;
    localparam int OUT_DATA_W = ((EVENT_W + LEFT_W + 7) / 8) * 8;

    // Header bits of a PS/2 mouse packet.
    localparam int HDR_SYNC_BIT  = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;

    // Command codes carried in the input tuser.
    localparam logic CMD_RX_BYTE = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    typedef enum logic [2:0] {
        ST_HEADER = 3'b001,
        ST_X      = 3'b010,
        ST_Y      = 3'b100
    } t_stage;

    typedef struct packed {
        logic               valid;
        logic [EVENT_W-1:0] event_data;
    } t_push;

endpackage

FILE: hw/rtl/ps2mf_ram.sv
module ps2mf_ram #(
    parameter int WIDTH = ps2mf_pkg::EVENT_W,
    parameter int DEPTH = ps2mf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/ps2mf_pkt.sv
module ps2mf_pkt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_byte_valid,
    input  logic [ps2mf_pkg::BYTE_W-1:0]  i_byte,
    output ps2mf_pkg::t_push              o_push
);

    ps2mf_pkg::t_stage               r_stage, n_stage;
    logic [ps2mf_pkg::BYTE_W-1:0]    r_header, n_header;
    logic [ps2mf_pkg::BYTE_W-1:0]    r_x_byte, n_x_byte;
    logic [ps2mf_pkg::X_MOVE_W-1:0]  x_move;
    logic [ps2mf_pkg::Y_MOVE_W-1:0]  y_raw;
    logic [ps2mf_pkg::Y_MOVE_W-1:0]  y_move;

    // X is the byte with the header sign on top; Y is sign-extended to ten
    // bits and negated so that upward motion becomes a negative screen step.
    assign x_move = {r_header[ps2mf_pkg::HDR_XSIGN_BIT], r_x_byte};
    assign y_raw  = {{2{r_header[ps2mf_pkg::HDR_YSIGN_BIT]}}, i_byte};
    assign y_move = ps2mf_pkg::Y_MOVE_W'(~y_raw + 1'b1);

    always_comb begin
        n_stage         = r_stage;
        n_header        = r_header;
        n_x_byte        = r_x_byte;
        o_push.valid      = 1'b0;
        o_push.event_data = {y_move, x_move, r_header[ps2mf_pkg::BUTTONS_W-1:0]};
        if (i_byte_valid) begin
            case (r_stage)
                ps2mf_pkg::ST_X: begin
                    n_x_byte = i_byte;
                    n_stage  = ps2mf_pkg::ST_Y;
                end
                ps2mf_pkg::ST_Y: begin
                    o_push.valid = 1'b1;
                    n_stage      = ps2mf_pkg::ST_HEADER;
                end
                default: begin
                    // A header without the sync bit is dropped.
                    if (i_byte[ps2mf_pkg::HDR_SYNC_BIT]) begin
                        n_header = i_byte;
                        n_stage  = ps2mf_pkg::ST_X;
                    end else begin
                        n_stage  = ps2mf_pkg::ST_HEADER;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= ps2mf_pkg::ST_HEADER;
        end else begin
            r_stage <= n_stage;
        end
        r_header <= n_header;
        r_x_byte <= n_x_byte;
    end

endmodule

FILE: hw/rtl/ps2_mouse_packet_fifo_unit.sv
// PS/2 mouse packet queue. Received mouse bytes and read requests share one
// input stream: tuser selects a received byte (0) or a read (1), and tdata
// carries the byte. Bytes are assembled into three-byte packets; a header
// without bit 3 set is dropped and the block waits for a valid header again.
// Each finished packet is decoded into buttons, signed X movement and negated
// signed Y movement and pushed into a ring of QUEUE_DEPTH slots held in one
// synchronous RAM, of which QUEUE_DEPTH-1 can be used; a packet that finds
// the queue full is lost. Every read returns exactly one output transaction:
// the oldest event with tuser set, or all zeros with tuser clear when the
// queue is empty. Received bytes produce no output. The block takes one
// input transaction every cycle; a read result passes through the RAM read
// register and then the output register. The input stalls only while an
// output result is held back by the sink. The event RAM needs no clearing
// after reset, so the block is ready at once.
module ps2_mouse_packet_fifo_unit #(
    parameter int QUEUE_DEPTH = ps2mf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // rx_byte [7:0]
    input  logic [ps2mf_pkg::BYTE_W-1:0]        s_axis_tdata,
    // command [0]
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // buttons [2:0], x_move [11:3], y_move [21:12], events_left [29:22],
    // zero padding [31:30]
    output logic [ps2mf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // event_valid [0]
    output logic [0:0]                          m_axis_tuser
);

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_W = $clog2(QUEUE_DEPTH);
    localparam int CMP_W   = (COUNT_W > ps2mf_pkg::LEFT_W) ? COUNT_W : ps2mf_pkg::LEFT_W;
    localparam int PAD_W   = ps2mf_pkg::OUT_DATA_W - ps2mf_pkg::EVENT_W - ps2mf_pkg::LEFT_W;

    // Pointers, fill count and the two output-side pipeline stages.
    logic [PTR_W-1:0]                  r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0]                  r_wr_ptr, n_wr_ptr;
    logic [COUNT_W-1:0]                r_count, n_count;
    logic                              r_p1_valid;
    logic                              r_p1_event_valid;
    logic [ps2mf_pkg::LEFT_W-1:0]      r_p1_left;
    logic                              r_out_valid;
    logic [ps2mf_pkg::OUT_DATA_W-1:0]  r_out_data;
    logic                              r_out_event_valid;

    logic                              accept;
    logic                              is_read;
    logic                              byte_valid;
    logic                              full;
    logic                              empty;
    logic                              wr_en;
    logic                              rd_en;
    logic                              p1_advance;
    logic [COUNT_W-1:0]                count_after_pop;
    logic [CMP_W-1:0]                  left_wide;
    logic [ps2mf_pkg::LEFT_W-1:0]      left_sat;
    logic [ps2mf_pkg::EVENT_W-1:0]     rd_event;
    ps2mf_pkg::t_push                  push;

    // A transaction is accepted when tvalid and tready meet at a clock edge.
    assign accept     = s_axis_tvalid && s_axis_tready;
    assign is_read    = (s_axis_tuser[0] == ps2mf_pkg::CMD_READ);
    assign byte_valid = accept && !is_read;

    // The output register frees up when empty or when the sink takes it.
    // The RAM read register is only reloaded when the first stage moves on,
    // so new input waits while a read result is stuck behind the sink.
    assign p1_advance    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_p1_valid || p1_advance;

    ps2mf_pkt u_pkt (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte_valid (byte_valid),
        .i_byte       (s_axis_tdata),
        .o_push       (push)
    );

    // One slot always stays free, so the count never reaches QUEUE_DEPTH.
    assign full  = (r_count == COUNT_W'(QUEUE_DEPTH - 1));
    assign empty = (r_count == '0);
    assign wr_en = push.valid && !full;
    assign rd_en = accept && is_read && !empty;

    // Events left after a pop, saturated to the eight-bit output field.
    assign count_after_pop = COUNT_W'(r_count - COUNT_W'(1));
    assign left_wide       = CMP_W'(count_after_pop);
    assign left_sat        = (left_wide > CMP_W'(255)) ? ps2mf_pkg::LEFT_W'(255)
                                                       : left_wide[ps2mf_pkg::LEFT_W-1:0];

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        // A push and a pop never happen in the same cycle, since one input
        // transaction is either a byte or a read.
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                             : PTR_W'(r_wr_ptr + 1'b1);
            n_count  = COUNT_W'(r_count + 1'b1);
        end else if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                             : PTR_W'(r_rd_ptr + 1'b1);
            n_count  = count_after_pop;
        end
    end

    ps2mf_ram #(
        .WIDTH (ps2mf_pkg::EVENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_event_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (push.event_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (rd_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_p1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (s_axis_tready) begin
                r_p1_valid <= accept && is_read;
            end
            if (p1_advance) begin
                r_out_valid <= r_p1_valid;
            end
        end
    end

    // Payload registers: first stage keeps the read metadata while the RAM
    // fetches the event; the output register merges both. An empty read
    // gives all zeros.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && accept && is_read) begin
            r_p1_event_valid <= !empty;
            r_p1_left        <= left_sat;
        end
        if (p1_advance && r_p1_valid) begin
            r_out_event_valid <= r_p1_event_valid;
            if (r_p1_event_valid) begin
                r_out_data <= {{PAD_W{1'b0}}, r_p1_left, rd_event};
            end else begin
                r_out_data <= '0;
            end
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_event_valid;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the PS/2 mouse packet queue. A stimulus process
// builds a list of stream words (received mouse bytes and read commands);
// a clocked driver feeds them into the slave port at the falling edge, with
// random sender gaps. A clocked monitor samples both ports at the rising
// edge: every accepted input word runs through a behavioral copy of the
// packet assembler and event ring, and every read pushes the result it
// must produce. Every output transaction is then compared field by field
// with the oldest pending read result.
module testbench;

    localparam int CLK_HALF    = 4;
    localparam int RING_SLOTS  = ps2mf_pkg::QUEUE_DEPTH_DEF;

    // Bit positions of the fields inside a packed event and the output tdata.
    localparam int BTN_W = ps2mf_pkg::BUTTONS_W;
    localparam int X_LSB = ps2mf_pkg::BUTTONS_W;
    localparam int X_MSB = X_LSB + ps2mf_pkg::X_MOVE_W - 1;
    localparam int Y_LSB = X_MSB + 1;
    localparam int Y_MSB = ps2mf_pkg::EVENT_W - 1;
    localparam int L_LSB = ps2mf_pkg::EVENT_W;
    localparam int L_MSB = L_LSB + ps2mf_pkg::LEFT_W - 1;
    localparam logic [ps2mf_pkg::BYTE_W-1:0] SYNC_MASK =
        ps2mf_pkg::BYTE_W'(1) << ps2mf_pkg::HDR_SYNC_BIT;

    // One word of the input stream: the command and the byte that rides with it.
    typedef struct packed {
        logic                           command;
        logic [ps2mf_pkg::BYTE_W-1:0]   rx_byte;
    } t_stream_word;

    // What a single read has to return.
    typedef struct {
        logic                             event_valid;
        logic [ps2mf_pkg::BUTTONS_W-1:0]  buttons;
        logic [ps2mf_pkg::X_MOVE_W-1:0]   x_move;
        logic [ps2mf_pkg::Y_MOVE_W-1:0]   y_move;
        logic [ps2mf_pkg::LEFT_W-1:0]     events_left;
    } t_read_result;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    // rx_byte [7:0]
    logic [ps2mf_pkg::BYTE_W-1:0]      s_axis_tdata = '0;
    // command [0]
    logic [0:0]                        s_axis_tuser = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    // buttons [2:0], x_move [11:3], y_move [21:12], events_left [29:22],
    // zero padding [31:30]
    logic [ps2mf_pkg::OUT_DATA_W-1:0]  m_axis_tdata;
    // event_valid [0]
    logic [0:0]                        m_axis_tuser;

    ps2_mouse_packet_fifo_unit #(
        .QUEUE_DEPTH(RING_SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Stimulus list, pending read results and the idling knobs of the phase.
    t_stream_word pending_words[$];
    t_read_result expected_reads[$];
    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;

    // Set by the monitor when the slave port completes a transaction, so the
    // driver knows at the next falling edge that it may move on.
    bit word_taken = 1'b0;
    t_stream_word next_word;

    // Behavioral copy of the packet assembler and the event ring.
    ps2mf_pkg::t_stage                pkt_stage = ps2mf_pkg::ST_HEADER;
    logic [ps2mf_pkg::BYTE_W-1:0]     hdr_latch = '0;
    logic [ps2mf_pkg::BYTE_W-1:0]     x_latch = '0;
    logic [ps2mf_pkg::EVENT_W-1:0]    event_ring [RING_SLOTS];
    int                               rd_slot = 0;
    int                               wr_slot = 0;

    // Byte stage as seen by the stimulus generator, used to realign packets.
    int gen_stage = 0;

    // Run statistics.
    int stim_words      = 0;
    int mismatches      = 0;
    int results_checked = 0;
    int events_popped   = 0;
    int empty_reads     = 0;
    int headers_dropped = 0;
    int packets_lost    = 0;
    int packets_queued  = 0;
    int peak_fill       = 0;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Generous ceiling; the slowest correct run needs well under a tenth of it.
    initial begin
        #2_000_000;
        $display("Timeout: the run did not drain in time.");
        $display("[ps2_mouse_packet_fifo_unit] ERROR");
        $finish;
    end

    function automatic logic [ps2mf_pkg::BYTE_W-1:0] rand_byte();
        return ps2mf_pkg::BYTE_W'($urandom_range(255));
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("%0t ns  MISMATCH: %s", $time, msg);
    endtask

    // Runs one accepted input word through the behavioral copy. A received
    // byte only moves the assembler; a read pops the oldest event, or gives
    // an all-zero result when the ring is empty.
    task automatic decode_mouse_input(input logic command,
                                      input logic [ps2mf_pkg::BYTE_W-1:0] b);
        t_read_result r;
        logic [ps2mf_pkg::EVENT_W-1:0] ev;
        logic [ps2mf_pkg::Y_MOVE_W-1:0] y_raw;
        int after_push;
        int left_cnt;
        if (command != ps2mf_pkg::CMD_READ) begin
            case (pkt_stage)
                ps2mf_pkg::ST_X: begin
                    x_latch = b;
                    pkt_stage = ps2mf_pkg::ST_Y;
                end
                ps2mf_pkg::ST_Y: begin
                    after_push = (wr_slot + 1) % RING_SLOTS;
                    if (after_push != rd_slot) begin
                        // Y is sign-extended to ten bits and negated, so a raw
                        // value of -256 turns into +256.
                        y_raw = {hdr_latch[ps2mf_pkg::HDR_YSIGN_BIT],
                                 hdr_latch[ps2mf_pkg::HDR_YSIGN_BIT], b};
                        ev[BTN_W-1:0] = hdr_latch[BTN_W-1:0];
                        ev[X_MSB:X_LSB] = {hdr_latch[ps2mf_pkg::HDR_XSIGN_BIT], x_latch};
                        ev[Y_MSB:Y_LSB] = '0 - y_raw;
                        event_ring[wr_slot] = ev;
                        wr_slot = after_push;
                        packets_queued++;
                    end else begin
                        packets_lost++;
                    end
                    pkt_stage = ps2mf_pkg::ST_HEADER;
                end
                default: begin
                    if (b[ps2mf_pkg::HDR_SYNC_BIT]) begin
                        hdr_latch = b;
                        pkt_stage = ps2mf_pkg::ST_X;
                    end else begin
                        headers_dropped++;
                        pkt_stage = ps2mf_pkg::ST_HEADER;
                    end
                end
            endcase
            left_cnt = wr_slot - rd_slot;
            if (left_cnt < 0) begin
                left_cnt += RING_SLOTS;
            end
            if (left_cnt > peak_fill) begin
                peak_fill = left_cnt;
            end
            return;
        end

        if (rd_slot == wr_slot) begin
            r.event_valid = 1'b0;
            r.buttons     = '0;
            r.x_move      = '0;
            r.y_move      = '0;
            r.events_left = '0;
            empty_reads++;
        end else begin
            ev = event_ring[rd_slot];
            rd_slot = (rd_slot + 1) % RING_SLOTS;
            left_cnt = wr_slot - rd_slot;
            if (left_cnt < 0) begin
                left_cnt += RING_SLOTS;
            end
            if (left_cnt > 255) begin
                left_cnt = 255;
            end
            r.event_valid = 1'b1;
            r.buttons     = ev[BTN_W-1:0];
            r.x_move      = ev[X_MSB:X_LSB];
            r.y_move      = ev[Y_MSB:Y_LSB];
            r.events_left = left_cnt[ps2mf_pkg::LEFT_W-1:0];
            events_popped++;
        end
        expected_reads.push_back(r);
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want) begin
            flag_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                    results_checked, name, got, want));
        end
    endtask

    task automatic check_read_result(input logic [ps2mf_pkg::OUT_DATA_W-1:0] data,
                                     input logic [0:0] flag);
        t_read_result want;
        if (expected_reads.size() == 0) begin
            flag_mismatch($sformatf("unexpected output transaction, tdata 0x%0h tuser %0b",
                                    data, flag));
            return;
        end
        want = expected_reads.pop_front();
        compare_field("event_valid", int'(flag[0]), int'(want.event_valid));
        compare_field("buttons", int'(data[BTN_W-1:0]), int'(want.buttons));
        compare_field("x_move", int'(data[X_MSB:X_LSB]), int'(want.x_move));
        compare_field("y_move", int'(data[Y_MSB:Y_LSB]), int'(want.y_move));
        compare_field("events_left", int'(data[L_MSB:L_LSB]), int'(want.events_left));
        compare_field("padding", int'(data[ps2mf_pkg::OUT_DATA_W-1:L_MSB+1]), 0);
        results_checked++;
    endtask

    // Monitor: samples both ports at the rising edge. The output of a read
    // always trails its input by the RAM read and output registers, so
    // updating the prediction before checking within the same edge is safe.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_taken = 1'b0;
        end else begin
            word_taken = s_axis_tvalid && s_axis_tready;
            if (word_taken) begin
                decode_mouse_input(s_axis_tuser[0], s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_read_result(m_axis_tdata, m_axis_tuser);
            end
        end
    end

    // Driver: moves on to a new word only once the current one was taken,
    // and inserts random gaps on the sender side. The sink stalls at random.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || word_taken) begin
            if (pending_words.size() != 0 && int'($urandom_range(99)) >= sender_idle_pct) begin
                next_word = pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= next_word.command;
                s_axis_tdata  <= next_word.rx_byte;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= (int'($urandom_range(99)) >= sink_stall_pct);
    end

    // Queues one received byte and tracks where the assembler will stand.
    task automatic push_byte(input logic [ps2mf_pkg::BYTE_W-1:0] b);
        t_stream_word w;
        w.command = ps2mf_pkg::CMD_RX_BYTE;
        w.rx_byte = b;
        pending_words.push_back(w);
        stim_words++;
        if (gen_stage == 1) begin
            gen_stage = 2;
        end else if (gen_stage == 2) begin
            gen_stage = 0;
        end else begin
            gen_stage = b[ps2mf_pkg::HDR_SYNC_BIT] ? 1 : 0;
        end
    endtask

    // The byte of a read is ignored by the block, so it is random.
    task automatic push_read();
        t_stream_word w;
        w.command = ps2mf_pkg::CMD_READ;
        w.rx_byte = rand_byte();
        pending_words.push_back(w);
        stim_words++;
    endtask

    // A well-formed packet; read_pct sets how often a read slips in between
    // its bytes. Any partial packet left by a broken sequence is finished first.
    task automatic push_packet(input logic [ps2mf_pkg::BYTE_W-1:0] hdr,
                               input logic [ps2mf_pkg::BYTE_W-1:0] xb,
                               input logic [ps2mf_pkg::BYTE_W-1:0] yb, input int read_pct);
        while (gen_stage != 0) begin
            push_byte(rand_byte());
        end
        push_byte(hdr | SYNC_MASK);
        if (int'($urandom_range(99)) < read_pct) begin
            push_read();
        end
        push_byte(xb);
        if (int'($urandom_range(99)) < read_pct) begin
            push_read();
        end
        push_byte(yb);
    endtask

    // Mixed traffic: mostly whole packets with random content, plus reads,
    // dropped headers, random noise bytes and packets cut short.
    task automatic push_traffic(input int n_words, input int read_pct);
        int start_words;
        int pick;
        start_words = stim_words;
        while (stim_words - start_words < n_words) begin
            pick = int'($urandom_range(99));
            if (pick < read_pct) begin
                push_read();
            end else if (pick < read_pct + (100 - read_pct) * 8 / 10) begin
                push_packet(rand_byte(), rand_byte(), rand_byte(), 10);
            end else if (pick < read_pct + (100 - read_pct) * 9 / 10) begin
                // Noise: usually a header without its sync bit.
                if ($urandom_range(3) != 0) begin
                    push_byte(rand_byte() & ~SYNC_MASK);
                end else begin
                    push_byte(rand_byte());
                end
            end else begin
                // A packet that stops after the header or after the X byte.
                while (gen_stage != 0) begin
                    push_byte(rand_byte());
                end
                push_byte(rand_byte() | SYNC_MASK);
                if ($urandom_range(1) != 0) begin
                    push_byte(rand_byte());
                end
            end
        end
    endtask

    task automatic wait_for_sender();
        while (pending_words.size() != 0 || s_axis_tvalid) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        int guard;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Phase 0, no idling. Directed cases first: a read of the empty ring,
        // headers without the sync bit, the movement extremes, reads in the
        // middle of a packet, and draining back to empty.
        push_read();
        push_byte(8'h00);
        push_byte(8'hF7);
        push_packet(8'h08, 8'h00, 8'h00, 0);
        push_packet(8'h3F, 8'h00, 8'h00, 0);
        push_packet(8'h08, 8'hFF, 8'hFF, 0);
        push_packet(8'hFF, 8'h01, 8'h01, 0);
        push_byte(8'h1D);
        push_read();
        push_byte(8'h80);
        push_read();
        push_byte(8'h7F);
        repeat (4) push_read();
        push_read();
        push_traffic(100, 35);
        wait_for_sender();

        // Phase 1, the sender idles most of the time.
        sender_idle_pct = 61;
        push_traffic(110, 35);
        wait_for_sender();

        // Phase 2, the sink stalls most of the time. Enough packets without
        // reads to fill the ring and lose some, then a few reads.
        sender_idle_pct = 0;
        sink_stall_pct  = 61;
        repeat (RING_SLOTS + 6) begin
            push_packet(rand_byte(), rand_byte(), rand_byte(), 0);
        end
        repeat (20) push_read();
        wait_for_sender();

        // Phase 3, both sides idle at random; read-heavy so the ring fill drops.
        sender_idle_pct = 33;
        sink_stall_pct  = 33;
        push_traffic(80, 60);
        wait_for_sender();

        // Let the last read results come out, which sink stalls can hold back.
        guard = 0;
        while (expected_reads.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_reads.size() != 0) begin
            flag_mismatch($sformatf("%0d read results never arrived", expected_reads.size()));
        end

        $display("Sent %0d words: %0d packets queued, %0d lost to a full ring, %0d %s",
                 stim_words, packets_queued, packets_lost, headers_dropped,
                 "headers dropped.");
        $display("Checked %0d reads (%0d events, %0d empty), peak fill %0d, %0d mismatches.",
                 results_checked, events_popped, empty_reads, peak_fill, mismatches);
        if (mismatches == 0) begin
            $display("[ps2_mouse_packet_fifo_unit] OK");
        end else begin
            $display("[ps2_mouse_packet_fifo_unit] ERROR");
        end
        $finish;
    end

endmodule
